### hdl/fre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fre_pkg
// Shared types, constants and helpers of the fragment reassembly engine.
// ----------------------------------------------------------------------------
package fre_pkg;

  localparam int unsigned SLOTS_DEF          = 4;
  localparam int unsigned MAX_PACKET_DEF     = 256;
  localparam int unsigned MAX_FRAG_BYTES_DEF = 64;
  localparam int unsigned MAX_FRAGS_DEF      = 32;

  // Stored length field is wide enough for the largest supported packet.
  localparam int unsigned TOTAL_W = 11;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned MASK_W  = 32;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [31:0] FNV_OFFSET    = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME     = 32'h0100_0193;

  localparam logic [2:0] STATUS_STORED   = 3'd0;
  localparam logic [2:0] STATUS_REJECT   = 3'd1;
  localparam logic [2:0] STATUS_MISMATCH = 3'd2;
  localparam logic [2:0] STATUS_CKSUM    = 3'd3;
  localparam logic [2:0] STATUS_DATA     = 3'd4;

  typedef enum logic [1:0] {
    FR_STORE    = 2'd0,
    FR_REJECT   = 2'd1,
    FR_MISMATCH = 2'd2
  } frag_mode_t;

  typedef struct packed {
    logic [63:0]         source;
    logic [31:0]         origin;
    logic [31:0]         ident;
    logic [TOTAL_W-1:0]  total;
    logic [COUNT_W-1:0]  count;
    logic [MASK_W-1:0]   mask;
    logic [31:0]         stamp;
  } slot_entry_t;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic        set_valid;
    logic        clr_valid;
    slot_entry_t wr_data;
  } slot_ctl_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] data_word;
    logic [3:0]  word_bytes;
    logic        last_word;
    logic [31:0] origin;
    logic [31:0] ident;
  } result_t;

  function automatic logic [MASK_W-1:0] full_mask(input logic [COUNT_W-1:0] count);
    logic [MASK_W:0] one_hot;
    begin
      one_hot = (MASK_W+1)'(1) << count;
      return MASK_W'(one_hot - 1'b1);
    end
  endfunction

endpackage
`default_nettype wire

### hdl/fre_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fre_if
// Fragment input channel and result output channel of the reassembly engine.
// ----------------------------------------------------------------------------
interface fre_frag_if;
  logic        valid;
  logic        ready;
  logic [63:0] source_address;
  logic [31:0] origin_node;
  logic [31:0] packet_ident;
  logic [15:0] total_length;
  logic [15:0] fragment_offset;
  logic [7:0]  fragment_index;
  logic [7:0]  fragment_count;
  logic [7:0]  fragment_length;
  logic [31:0] packet_checksum;
  logic [7:0]  data_byte;
  logic [31:0] now_ms;

  modport source (
    output valid, source_address, origin_node, packet_ident, total_length,
           fragment_offset, fragment_index, fragment_count, fragment_length,
           packet_checksum, data_byte, now_ms,
    input  ready
  );
  modport sink (
    input  valid, source_address, origin_node, packet_ident, total_length,
           fragment_offset, fragment_index, fragment_count, fragment_length,
           packet_checksum, data_byte, now_ms,
    output ready
  );
endinterface

interface fre_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] data_word;
  logic [3:0]  word_bytes;
  logic        last_word;
  logic [31:0] out_origin_node;
  logic [31:0] out_packet_ident;

  modport source (
    output valid, status, data_word, word_bytes, last_word, out_origin_node,
           out_packet_ident,
    input  ready
  );
  modport sink (
    input  valid, status, data_word, word_bytes, last_word, out_origin_node,
           out_packet_ident,
    output ready
  );
endinterface
`default_nettype wire

### hdl/fre_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fre_slot_mem
// Context slot table: one synchronous memory of slot entries with a
// registered read port, plus a valid flag per slot that reset clears.
// ----------------------------------------------------------------------------
module fre_slot_mem
  import fre_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire slot_ctl_t   ctl,
  input  wire logic [SW-1:0] rd_addr,
  input  wire logic [SW-1:0] wr_addr,
  output slot_entry_t      rd_entry,
  output logic             rd_valid
);

  slot_entry_t      mem [SLOTS];
  logic [SLOTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr_en && ctl.set_valid) begin
      valid[wr_addr] <= 1'b1;
    end else if (ctl.clr_valid) begin
      valid[wr_addr] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### hdl/fre_byte_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fre_byte_mem
// Packet byte store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module fre_byte_mem #(
  parameter int unsigned AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/fre_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fre_ctrl
// Sequencer: header check, slot search over the slot table, byte stores,
// slot clearing, completion hash pass, word emission and the result register.
// ----------------------------------------------------------------------------
module fre_ctrl
  import fre_pkg::*;
#(
  parameter int unsigned SLOTS          = SLOTS_DEF,
  parameter int unsigned MAX_PACKET     = MAX_PACKET_DEF,
  parameter int unsigned MAX_FRAG_BYTES = MAX_FRAG_BYTES_DEF,
  parameter int unsigned MAX_FRAGS      = MAX_FRAGS_DEF,
  parameter int unsigned SW             = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int unsigned PW             = $clog2(MAX_PACKET)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [15:0]   timeout,
  fre_frag_if.sink           fragment,
  fre_result_if.source       result,
  output slot_ctl_t          slot_ctl,
  output logic [SW-1:0]      slot_rd_addr,
  output logic [SW-1:0]      slot_wr_addr,
  input  wire slot_entry_t   slot_rd_entry,
  input  wire logic          slot_rd_valid,
  output logic               byte_we,
  output logic [SW+PW-1:0]   byte_waddr,
  output logic [7:0]         byte_wdata,
  output logic               byte_re,
  output logic [SW+PW-1:0]   byte_raddr,
  input  wire logic [7:0]    byte_rdata
);

  localparam int unsigned CW  = PW + 1;
  localparam int unsigned SCW = $clog2(SLOTS + 1);

  typedef enum logic [11:0] {
    S_ACCEPT = 12'b0000_0000_0001,
    S_SEARCH = 12'b0000_0000_0010,
    S_DECIDE = 12'b0000_0000_0100,
    S_CLEAR  = 12'b0000_0000_1000,
    S_FIRST  = 12'b0000_0001_0000,
    S_FINISH = 12'b0000_0010_0000,
    S_MASK   = 12'b0000_0100_0000,
    S_HASH   = 12'b0000_1000_0000,
    S_CHECK  = 12'b0001_0000_0000,
    S_EMIT   = 12'b0010_0000_0000,
    S_PUSH   = 12'b0100_0000_0000,
    S_REPORT = 12'b1000_0000_0000
  } state_t;

  state_t              state;
  logic                frag_open;
  frag_mode_t          mode;
  logic [63:0]         h_source;
  logic [31:0]         h_origin;
  logic [31:0]         h_ident;
  logic [15:0]         h_total;
  logic [15:0]         h_offset;
  logic [4:0]          h_index;
  logic [COUNT_W-1:0]  h_count;
  logic [7:0]          h_len;
  logic [31:0]         h_sum;
  logic [7:0]          h_byte;
  logic [31:0]         h_now;
  logic [7:0]          cnt;
  logic [SW-1:0]       slot;
  logic [2:0]          rep_status;

  logic [SCW-1:0]      sidx;
  logic                spend;
  logic [SW-1:0]       spend_idx;
  logic                found;
  logic [SW-1:0]       found_idx;
  logic [TOTAL_W-1:0]  found_total;
  logic [COUNT_W-1:0]  found_count;
  logic                free_found;
  logic [SW-1:0]       free_idx;
  logic [31:0]         min_time;
  logic [SW-1:0]       min_idx;

  logic [PW-1:0]       clr_ptr;
  logic [CW-1:0]       ptr;
  logic                pend;
  logic [CW-1:0]       pend_ptr;
  logic [CW-1:0]       wbase;
  logic [31:0]         hash;
  logic [63:0]         word;

  logic                out_valid;
  result_t             out_data;

  logic                accept;
  logic                can_push;
  logic                push;
  logic                hdr_bad;
  logic [16:0]         hdr_end;
  logic                key_hit;
  logic                free_hit;
  logic [SW-1:0]       pick;
  logic [CW-1:0]       total_c;
  logic [CW:0]         wsum;
  logic [CW-1:0]       wend;
  logic [CW-1:0]       limit;
  logic                issue;
  logic [PW-1:0]       pos;
  logic [MASK_W-1:0]   new_mask;
  logic                mask_full;
  logic                cont_end;

  assign fragment.ready = (state == S_ACCEPT);
  assign accept         = fragment.valid && fragment.ready;
  assign can_push       = !out_valid || result.ready;
  assign push           = ((state == S_PUSH) || (state == S_REPORT)) && can_push;

  assign result.valid            = out_valid;
  assign result.status           = out_data.status;
  assign result.data_word        = out_data.data_word;
  assign result.word_bytes       = out_data.word_bytes;
  assign result.last_word        = out_data.last_word;
  assign result.out_origin_node  = out_data.origin;
  assign result.out_packet_ident = out_data.ident;

  assign hdr_end = {1'b0, fragment.fragment_offset} + 17'(fragment.fragment_length);
  assign hdr_bad = (fragment.fragment_count == 8'd0)
                || (fragment.fragment_count > 8'(MAX_FRAGS))
                || (fragment.fragment_index >= fragment.fragment_count)
                || (fragment.fragment_length > 8'(MAX_FRAG_BYTES))
                || (fragment.total_length == 16'd0)
                || ({1'b0, fragment.total_length} > 17'(MAX_PACKET))
                || (hdr_end > {1'b0, fragment.total_length});

  assign key_hit  = slot_rd_valid && (slot_rd_entry.source == h_source)
                 && (slot_rd_entry.origin == h_origin) && (slot_rd_entry.ident == h_ident);
  assign free_hit = !slot_rd_valid || ((h_now - slot_rd_entry.stamp) > {16'd0, timeout});
  assign pick     = free_found ? free_idx : min_idx;

  assign total_c = CW'(h_total);
  assign wsum    = {1'b0, wbase} + (CW+1)'(8);
  assign wend    = (wsum > {1'b0, total_c}) ? total_c : wsum[CW-1:0];
  assign limit   = (state == S_HASH) ? total_c : wend;
  assign issue   = ((state == S_HASH) || (state == S_EMIT)) && (ptr < limit);

  assign pos       = h_offset[PW-1:0] + PW'(cnt);
  assign new_mask  = slot_rd_entry.mask | (MASK_W'(1) << h_index);
  assign mask_full = (new_mask == full_mask(h_count));
  assign cont_end  = ({1'b0, cnt} + 9'd1) >= {1'b0, h_len};

  // Memory requests. Slot entries are written and read in distinct states,
  // so no access to one entry ever overlaps another.
  always_comb begin
    slot_ctl     = '0;
    slot_rd_addr = slot;
    slot_wr_addr = slot;
    byte_we      = 1'b0;
    byte_waddr   = {slot, pos};
    byte_wdata   = fragment.data_byte;
    byte_re      = issue;
    byte_raddr   = {slot, ptr[PW-1:0]};
    unique case (state)
      S_ACCEPT: begin
        byte_we = accept && frag_open && (mode == FR_STORE);
      end
      S_SEARCH: begin
        slot_ctl.rd_en = (sidx < SCW'(SLOTS));
        slot_rd_addr   = sidx[SW-1:0];
      end
      S_DECIDE: begin
        slot_ctl.wr_en          = !found;
        slot_ctl.set_valid      = !found;
        slot_wr_addr            = pick;
        slot_ctl.wr_data.source = h_source;
        slot_ctl.wr_data.origin = h_origin;
        slot_ctl.wr_data.ident  = h_ident;
        slot_ctl.wr_data.total  = h_total[TOTAL_W-1:0];
        slot_ctl.wr_data.count  = h_count;
        slot_ctl.wr_data.mask   = '0;
        slot_ctl.wr_data.stamp  = h_now;
      end
      S_CLEAR: begin
        byte_we    = 1'b1;
        byte_waddr = {slot, clr_ptr};
        byte_wdata = 8'd0;
      end
      S_FIRST: begin
        byte_we    = (h_len != 8'd0);
        byte_waddr = {slot, h_offset[PW-1:0]};
        byte_wdata = h_byte;
      end
      S_FINISH: begin
        slot_ctl.rd_en = 1'b1;
      end
      S_MASK: begin
        slot_ctl.wr_en         = 1'b1;
        slot_ctl.clr_valid     = mask_full;
        slot_ctl.wr_data       = slot_rd_entry;
        slot_ctl.wr_data.mask  = new_mask;
        slot_ctl.wr_data.stamp = h_now;
      end
      S_HASH, S_CHECK, S_EMIT, S_PUSH, S_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCEPT;
      frag_open <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
      spend     <= 1'b0;
      pend      <= 1'b0;
    end else begin
      out_valid <= push || (out_valid && !result.ready);
      unique case (state)
        S_ACCEPT: begin
          if (accept) begin
            h_now <= fragment.now_ms;
            if (!frag_open) begin
              h_source <= fragment.source_address;
              h_origin <= fragment.origin_node;
              h_ident  <= fragment.packet_ident;
              h_total  <= fragment.total_length;
              h_offset <= fragment.fragment_offset;
              h_index  <= fragment.fragment_index[4:0];
              h_count  <= fragment.fragment_count[COUNT_W-1:0];
              h_len    <= fragment.fragment_length;
              h_sum    <= fragment.packet_checksum;
              h_byte   <= fragment.data_byte;
              if (hdr_bad) begin
                mode <= FR_REJECT;
                if (fragment.fragment_length <= 8'd1) begin
                  rep_status <= STATUS_REJECT;
                  state      <= S_REPORT;
                end else begin
                  cnt       <= 8'd1;
                  frag_open <= 1'b1;
                end
              end else begin
                sidx       <= '0;
                spend      <= 1'b0;
                found      <= 1'b0;
                free_found <= 1'b0;
                state      <= S_SEARCH;
              end
            end else begin
              if (cont_end) begin
                frag_open <= 1'b0;
                cnt       <= '0;
                unique case (mode)
                  FR_STORE: state <= S_FINISH;
                  FR_REJECT: begin
                    rep_status <= STATUS_REJECT;
                    state      <= S_REPORT;
                  end
                  FR_MISMATCH: begin
                    rep_status <= STATUS_MISMATCH;
                    state      <= S_REPORT;
                  end
                  default: state <= S_ACCEPT;
                endcase
              end else begin
                cnt <= cnt + 8'd1;
              end
            end
          end
        end
        S_SEARCH: begin
          if (sidx < SCW'(SLOTS)) begin
            sidx <= sidx + 1'b1;
          end
          spend     <= (sidx < SCW'(SLOTS));
          spend_idx <= sidx[SW-1:0];
          if (spend) begin
            if (key_hit && !found) begin
              found       <= 1'b1;
              found_idx   <= spend_idx;
              found_total <= slot_rd_entry.total;
              found_count <= slot_rd_entry.count;
            end
            if (free_hit && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= spend_idx;
            end
            // Strict compare keeps the lowest slot among equal stamps.
            if ((spend_idx == '0) || (slot_rd_entry.stamp < min_time)) begin
              min_time <= slot_rd_entry.stamp;
              min_idx  <= spend_idx;
            end
            if (spend_idx == SW'(SLOTS - 1)) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (found) begin
            if ((found_total != h_total[TOTAL_W-1:0]) || (found_count != h_count)) begin
              mode <= FR_MISMATCH;
              if (h_len <= 8'd1) begin
                rep_status <= STATUS_MISMATCH;
                state      <= S_REPORT;
              end else begin
                cnt       <= 8'd1;
                frag_open <= 1'b1;
                state     <= S_ACCEPT;
              end
            end else begin
              mode  <= FR_STORE;
              slot  <= found_idx;
              state <= S_FIRST;
            end
          end else begin
            mode    <= FR_STORE;
            slot    <= pick;
            clr_ptr <= '0;
            state   <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == PW'(total_c - 1'b1)) begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          cnt <= 8'd1;
          if (h_len <= 8'd1) begin
            state <= S_FINISH;
          end else begin
            frag_open <= 1'b1;
            state     <= S_ACCEPT;
          end
        end
        S_FINISH: begin
          cnt   <= '0;
          state <= S_MASK;
        end
        S_MASK: begin
          if (mask_full) begin
            hash  <= FNV_OFFSET;
            ptr   <= '0;
            pend  <= 1'b0;
            state <= S_HASH;
          end else begin
            rep_status <= STATUS_STORED;
            state      <= S_REPORT;
          end
        end
        S_HASH: begin
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          pend     <= issue;
          pend_ptr <= ptr;
          if (pend) begin
            hash <= (hash ^ {24'd0, byte_rdata}) * FNV_PRIME;
            if (pend_ptr == total_c - 1'b1) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (hash != h_sum) begin
            rep_status <= STATUS_CKSUM;
            state      <= S_REPORT;
          end else begin
            ptr   <= '0;
            wbase <= '0;
            word  <= '0;
            pend  <= 1'b0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          pend     <= issue;
          pend_ptr <= ptr;
          if (pend) begin
            word[{pend_ptr[2:0], 3'b000} +: 8] <= byte_rdata;
            if (pend_ptr == wend - 1'b1) begin
              state <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          if (can_push) begin
            out_data.status     <= STATUS_DATA;
            out_data.data_word  <= word;
            out_data.word_bytes <= 4'(wend - wbase);
            out_data.last_word  <= (wend == total_c);
            out_data.origin     <= h_origin;
            out_data.ident      <= h_ident;
            if (wend == total_c) begin
              state <= S_ACCEPT;
            end else begin
              wbase <= wend;
              word  <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_REPORT: begin
          if (can_push) begin
            out_data.status     <= rep_status;
            out_data.data_word  <= '0;
            out_data.word_bytes <= '0;
            out_data.last_word  <= 1'b1;
            out_data.origin     <= h_origin;
            out_data.ident      <= h_ident;
            state               <= S_ACCEPT;
          end
        end
        default: state <= S_ACCEPT;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/fragment_reassembly_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_reassembly_engine
// Rebuilds fragmented packets one payload byte per transaction, tracks
// received fragments per context slot and emits checked packets as words.
// ----------------------------------------------------------------------------
//  Channel    | Kind        | Moves per transaction
//  -----------+-------------+------------------------------------------------
//  fragment   | valid/ready | one payload byte plus the fragment header fields
//  result     | valid/ready | one status, or one word of up to 8 bytes of a packet
//  cfg        | write only  | idle timeout in milliseconds, no read-back
//
// Continuation bytes are stored straight from the accept state. A fragment's
// first byte starts the walk over the slot table; when a new slot is taken,
// its bytes are zeroed first. Completion reads the slot entry, updates its
// mask and, once the mask is full, runs a hash pass over the byte store;
// a packet whose hash matches its checksum leaves as output words. Reset
// clears the slot valid flags. A stalled result holds in the output register
// while the next bytes are still taken.
// ----------------------------------------------------------------------------
module fragment_reassembly_engine
  import fre_pkg::*;
#(
  parameter int unsigned SLOTS          = SLOTS_DEF,
  parameter int unsigned MAX_PACKET     = MAX_PACKET_DEF,
  parameter int unsigned MAX_FRAG_BYTES = MAX_FRAG_BYTES_DEF,
  parameter int unsigned MAX_FRAGS      = MAX_FRAGS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  fre_frag_if.sink         fragment,
  fre_result_if.source     result,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW = $clog2(MAX_PACKET);

  logic [15:0]      timeout;
  slot_ctl_t        slot_ctl;
  logic [SW-1:0]    slot_rd_addr;
  logic [SW-1:0]    slot_wr_addr;
  slot_entry_t      slot_rd_entry;
  logic             slot_rd_valid;
  logic             byte_we;
  logic [SW+PW-1:0] byte_waddr;
  logic [7:0]       byte_wdata;
  logic             byte_re;
  logic [SW+PW-1:0] byte_raddr;
  logic [7:0]       byte_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  fre_ctrl #(
    .SLOTS          (SLOTS),
    .MAX_PACKET     (MAX_PACKET),
    .MAX_FRAG_BYTES (MAX_FRAG_BYTES),
    .MAX_FRAGS      (MAX_FRAGS),
    .SW             (SW),
    .PW             (PW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .timeout       (timeout),
    .fragment      (fragment),
    .result        (result),
    .slot_ctl      (slot_ctl),
    .slot_rd_addr  (slot_rd_addr),
    .slot_wr_addr  (slot_wr_addr),
    .slot_rd_entry (slot_rd_entry),
    .slot_rd_valid (slot_rd_valid),
    .byte_we       (byte_we),
    .byte_waddr    (byte_waddr),
    .byte_wdata    (byte_wdata),
    .byte_re       (byte_re),
    .byte_raddr    (byte_raddr),
    .byte_rdata    (byte_rdata)
  );

  fre_slot_mem #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_slot_mem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (slot_ctl),
    .rd_addr  (slot_rd_addr),
    .wr_addr  (slot_wr_addr),
    .rd_entry (slot_rd_entry),
    .rd_valid (slot_rd_valid)
  );

  fre_byte_mem #(
    .AW (SW + PW)
  ) u_byte_mem (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .re    (byte_re),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

endmodule
`default_nettype wire

### hdl/fre_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fre_checker
// Port-level checks on the result channel of the reassembly engine.
// ----------------------------------------------------------------------------
module fre_checker
  import fre_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [63:0] data_word,
  input wire logic [3:0]  word_bytes,
  input wire logic        last_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_DATA) |->
      (word_bytes == 4'd0) && last_word && (data_word == 64'd0))
    else $error("status result carries data");

  a_data_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_DATA) |-> (word_bytes != 4'd0) && (word_bytes <= 4'd8))
    else $error("data word byte count out of range");

  a_partial_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_DATA) && (word_bytes != 4'd8) |-> last_word)
    else $error("partial data word is not the last one");

endmodule

bind fragment_reassembly_engine fre_checker u_fre_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .status     (result.status),
  .data_word  (result.data_word),
  .word_bytes (result.word_bytes),
  .last_word  (result.last_word)
);
`default_nettype wire

### test/fragment_reassembly_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_reassembly_engine_tb
// Self-checking bench for the fragment reassembly engine. A directed table of
// fragments covers header rejection, slot mismatch, checksum errors and zero
// length fragments. It is followed by short random bursts of interleaved
// packets with noise, drops and duplicates, run under several timeout
// settings. Every result transaction is compared with a bit-accurate
// predictor of slot search, byte storage, hashing and word output, or, for a typed directed row, with the row's status.
// ----------------------------------------------------------------------------
module fragment_reassembly_engine_tb;
  import fre_pkg::*;

  localparam int NSLOT    = 4;
  localparam int PKT_MAX  = 256;
  localparam int FRAG_MAX = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] src;
    logic [31:0] org;
    logic [31:0] idn;
    logic [15:0] tot;
    logic [15:0] off;
    logic [7:0]  idx;
    logic [7:0]  cnt;
    logic [7:0]  len;
    logic [31:0] sum;
    logic [7:0]  dbyte;
    logic [31:0] now;
  } item_t;

  typedef struct {
    item_t      hd;
    logic [7:0] dat [PKT_MAX];
    bit         typed;
    logic [2:0] st;
  } frag_row_t;

  typedef enum {F_IDLE, F_STORE, F_REJECT, F_MISMATCH} frag_phase_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  fre_frag_if   fi ();
  fre_result_if ri ();

  fragment_reassembly_engine DUT (
    .clk        (clk),
    .rst        (rst),
    .fragment   (fi),
    .result     (ri),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state.
  logic [15:0] timeout_ms;
  bit          slot_used [NSLOT];
  logic [63:0] slot_src [NSLOT];
  logic [31:0] slot_org [NSLOT];
  logic [31:0] slot_idn [NSLOT];
  int          slot_tot [NSLOT];
  int          slot_cnt [NSLOT];
  logic [31:0] slot_mask [NSLOT];
  logic [31:0] slot_stamp [NSLOT];
  logic [7:0]  byte_store [NSLOT][PKT_MAX];
  frag_phase_t frag_phase;
  int          frag_bytes;
  int          open_slot;
  item_t       open_hdr;

  result_t     pending_results [$];
  frag_row_t   frag_list [$];
  int          errors;
  int          results_seen;
  logic [31:0] clock_ms;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] fnv_hash(input logic [7:0] d [PKT_MAX], input int n);
    logic [31:0] h;
    h = FNV_OFFSET;
    for (int i = 0; i < n; i++) h = (h ^ {24'd0, d[i]}) * FNV_PRIME;
    return h;
  endfunction

  function automatic void add_result(logic [2:0] st, logic [63:0] w, logic [3:0] nb,
                                     logic last);
    result_t r;
    r.status = st;
    r.data_word = w;
    r.word_bytes = nb;
    r.last_word = last;
    r.origin = open_hdr.org;
    r.ident = open_hdr.idn;
    pending_results.push_back(r);
  endfunction

  function automatic int claim_slot(logic [63:0] src, logic [31:0] now);
    int pick;
    logic [31:0] age;
    pick = -1;
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_src[i] == src && slot_org[i] == open_hdr.org &&
          slot_idn[i] == open_hdr.idn) return i;
    for (int i = 0; i < NSLOT; i++) begin
      age = now - slot_stamp[i];
      if (pick < 0 && (!slot_used[i] || age > {16'd0, timeout_ms})) pick = i;
    end
    if (pick < 0) begin
      pick = 0;
      for (int i = 0; i < NSLOT; i++)
        if (slot_stamp[i] < slot_stamp[pick]) pick = i;
    end
    slot_used[pick] = 1'b1;
    slot_src[pick] = src;
    slot_org[pick] = open_hdr.org;
    slot_idn[pick] = open_hdr.idn;
    slot_tot[pick] = open_hdr.tot;
    slot_cnt[pick] = open_hdr.cnt;
    slot_mask[pick] = '0;
    slot_stamp[pick] = now;
    for (int i = 0; i < PKT_MAX; i++) byte_store[pick][i] = 8'd0;
    return pick;
  endfunction

  function automatic void close_fragment(logic [31:0] now);
    logic [31:0] full;
    logic [63:0] w;
    int s, total, nw, nb;
    s = open_slot;
    if (frag_phase != F_STORE) begin
      add_result(frag_phase == F_REJECT ? STATUS_REJECT : STATUS_MISMATCH, '0, '0, 1'b1);
      frag_phase = F_IDLE;
      frag_bytes = 0;
      return;
    end
    frag_phase = F_IDLE;
    frag_bytes = 0;
    slot_mask[s] |= 32'd1 << open_hdr.idx[4:0];
    slot_stamp[s] = now;
    full = (open_hdr.cnt >= 32) ? '1 : ((32'd1 << open_hdr.cnt) - 32'd1);
    if (slot_mask[s] != full) begin
      add_result(STATUS_STORED, '0, '0, 1'b1);
      return;
    end
    total = slot_tot[s];
    slot_used[s] = 1'b0;
    if (fnv_hash(byte_store[s], total) != open_hdr.sum) begin
      add_result(STATUS_CKSUM, '0, '0, 1'b1);
      return;
    end
    nw = (total + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      nb = (total - k * 8 > 8) ? 8 : total - k * 8;
      w = '0;
      for (int b = 0; b < nb; b++) w |= {56'd0, byte_store[s][k * 8 + b]} << (8 * b);
      add_result(STATUS_DATA, w, 4'(nb), k + 1 == nw);
    end
  endfunction

  // Advances the predicted engine by one accepted fragment transaction.
  function automatic void reassembly_predict(item_t it);
    bit bad;
    if (frag_phase == F_IDLE) begin
      open_hdr = it;
      frag_bytes = 0;
      open_slot = -1;
      bad = it.cnt == 0 || it.cnt > 32 || it.idx >= it.cnt || it.len > FRAG_MAX ||
            it.tot == 0 || it.tot > PKT_MAX || int'(it.off) + int'(it.len) > int'(it.tot);
      if (bad) frag_phase = F_REJECT;
      else begin
        open_slot = claim_slot(it.src, it.now);
        if (slot_tot[open_slot] != it.tot || slot_cnt[open_slot] != it.cnt) begin
          frag_phase = F_MISMATCH;
          open_slot = -1;
        end else frag_phase = F_STORE;
      end
      if (it.len == 0) begin
        close_fragment(it.now);
        return;
      end
    end
    if (frag_phase == F_STORE) byte_store[open_slot][open_hdr.off + frag_bytes] = it.dbyte;
    frag_bytes = (frag_bytes + 1) & 255;
    if (frag_bytes < open_hdr.len) return;
    close_fragment(it.now);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic drive_item(item_t it);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      fi.valid = 1'b0;
    end
    @(negedge clk);
    {fi.source_address, fi.origin_node, fi.packet_ident, fi.total_length,
     fi.fragment_offset, fi.fragment_index, fi.fragment_count, fi.fragment_length,
     fi.packet_checksum, fi.data_byte, fi.now_ms} = it;
    fi.valid = 1'b1;
    do @(posedge clk); while (!fi.ready);
    reassembly_predict(it);
  endtask

  task automatic send_fragment(frag_row_t row);
    item_t it;
    int n;
    n = (row.hd.len == 0) ? 1 : row.hd.len;
    for (int k = 0; k < n; k++) begin
      // Header fields of continuation transactions are ignored, so they carry noise.
      if (k == 0) it = row.hd;
      else it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom};
      it.dbyte = row.dat[k];
      clock_ms += $urandom_range(0, 2);
      it.now = clock_ms;
      drive_item(it);
      // A typed row stands in for the single status of its closing transaction.
      if (row.typed && k == n - 1) begin
        void'(pending_results.pop_back());
        add_result(row.st, '0, '0, 1'b1);
      end
    end
    @(negedge clk);
    fi.valid = 1'b0;
  endtask

  function automatic frag_row_t hdr_row(logic [63:0] src, logic [31:0] org, logic [31:0] idn,
                                        int tot, int off, int idx, int cnt, int len,
                                        logic [31:0] sum, bit typed, logic [2:0] st);
    frag_row_t r;
    r.hd = '0;
    r.hd.src = src; r.hd.org = org; r.hd.idn = idn;
    r.hd.tot = 16'(tot); r.hd.off = 16'(off); r.hd.idx = 8'(idx);
    r.hd.cnt = 8'(cnt); r.hd.len = 8'(len); r.hd.sum = sum;
    for (int i = 0; i < PKT_MAX; i++) r.dat[i] = 8'($urandom);
    r.typed = typed;
    r.st = st;
    return r;
  endfunction

  // Splits one packet into fragments and appends them to the fragment list.
  task automatic make_packet(logic [63:0] src, logic [31:0] org, logic [31:0] idn,
                             int total, int cnt, bit bad_sum);
    logic [7:0] pkt [PKT_MAX];
    logic [31:0] sum;
    frag_row_t r;
    int base, rem, off, len, style;
    style = $urandom_range(0, 9);
    for (int i = 0; i < PKT_MAX; i++)
      pkt[i] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom);
    sum = fnv_hash(pkt, total);
    if (bad_sum) sum ^= 32'd1 << $urandom_range(0, 31);
    base = total / cnt;
    rem = total % cnt;
    off = 0;
    for (int i = 0; i < cnt; i++) begin
      len = base + (i < rem ? 1 : 0);
      r = hdr_row(src, org, idn, total, off, i, cnt, len, sum, 1'b0, STATUS_STORED);
      for (int b = 0; b < len; b++) r.dat[b] = pkt[off + b];
      frag_list.push_back(r);
      off += len;
    end
  endtask

  task automatic write_timeout(logic [15:0] v);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    timeout_ms = v;
  endtask

  task automatic random_burst();
    logic [63:0] src_pool [3];
    frag_row_t r, t;
    int npk, total, lo, hi, cnt, j, n;
    src_pool[0] = {$urandom, $urandom};
    src_pool[1] = '1;
    src_pool[2] = '0;
    npk = $urandom_range(1, 2);
    frag_list.delete();
    for (int p = 0; p < npk; p++) begin
      n = $urandom_range(0, 9);
      total = (n < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      lo = (total + FRAG_MAX - 1) / FRAG_MAX;
      hi = (total + 2 < 32) ? total + 2 : 32;
      cnt = ($urandom_range(0, 19) == 0) ? 32 : $urandom_range(lo, hi);
      make_packet($urandom_range(0, 1) ? src_pool[$urandom_range(0, 2)] : {$urandom, $urandom},
                  $urandom, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom,
                  total, cnt, $urandom_range(0, 6) == 0);
    end
    for (int i = frag_list.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = frag_list[i];
      frag_list[i] = frag_list[j];
      frag_list[j] = t;
    end
    if ($urandom_range(0, 3) == 0) clock_ms += $urandom;
    else if ($urandom_range(0, 2) == 0) clock_ms += {16'd0, timeout_ms} + $urandom_range(0, 2);
    while (frag_list.size() != 0) begin
      r = frag_list.pop_front();
      n = $urandom_range(0, 99);
      if (n < 4) continue;             // lost fragment
      if (n < 8) frag_list.push_back(r); // duplicate later
      if (n >= 8 && n < 12) begin
        t = r;
        t.hd.tot = r.hd.tot + 16'd1;   // same key, different total
        send_fragment(t);
      end else if (n >= 12 && n < 20) begin
        t = r;
        t.hd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom};
        t.hd.len = 8'($urandom_range(0, 8));
        send_fragment(t);
      end
      send_fragment(r);
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && ri.valid && ri.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, status %0d", $time, ri.status);
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, ri.status);
        check_field("data_word", e.data_word, ri.data_word);
        check_field("word_bytes", e.word_bytes, ri.word_bytes);
        check_field("last_word", e.last_word, ri.last_word);
        check_field("origin", e.origin, ri.out_origin_node);
        check_field("ident", e.ident, ri.out_packet_ident);
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off to back up the input.
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    ri.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 5) begin
        held = 1'b1;
        stall = 600;
      end
      if (stall > 0) begin
        ri.ready = 1'b0;
        stall--;
      end else begin
        ri.ready = 1'b1;
        if (!no_gaps) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    int idle;
    if (rst || (fi.valid && fi.ready) || (ri.valid && ri.ready)) idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    frag_row_t tbl [$];
    logic [15:0] tmo_set [4];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    fi.valid = 1'b0;
    {fi.source_address, fi.origin_node, fi.packet_ident, fi.total_length,
     fi.fragment_offset, fi.fragment_index, fi.fragment_count, fi.fragment_length,
     fi.packet_checksum, fi.data_byte, fi.now_ms} = '0;
    errors = 0;
    results_seen = 0;
    no_gaps = 1'b0;
    clock_ms = $urandom;
    timeout_ms = TIMEOUT_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0; slot_src[i] = '0; slot_org[i] = '0; slot_idn[i] = '0;
      slot_tot[i] = 0; slot_cnt[i] = 0; slot_mask[i] = '0; slot_stamp[i] = '0;
    end
    frag_phase = F_IDLE;
    frag_bytes = 0;
    open_slot = -1;
    open_hdr = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: header rejections, checksum error, zero length and mismatch.
    tbl.push_back(hdr_row(64'h1, 32'h1, 32'h1, 10, 0, 0, 0, 0, 0, 1'b1, STATUS_REJECT));
    tbl.push_back(hdr_row(64'h1, 32'h1, 32'h2, 10, 0, 0, 33, 0, 0, 1'b1, STATUS_REJECT));
    tbl.push_back(hdr_row(64'h1, 32'h1, 32'h3, 10, 0, 5, 5, 0, 0, 1'b1, STATUS_REJECT));
    tbl.push_back(hdr_row(64'h1, 32'h1, 32'h4, 100, 0, 0, 2, 65, 0, 1'b1, STATUS_REJECT));
    tbl.push_back(hdr_row(64'h1, 32'h1, 32'h5, 0, 0, 0, 1, 0, 0, 1'b1, STATUS_REJECT));
    tbl.push_back(hdr_row(64'h1, 32'h1, 32'h6, 257, 0, 0, 1, 1, 0, 1'b1, STATUS_REJECT));
    tbl.push_back(hdr_row(64'h1, 32'h1, 32'h7, 256, 65535, 0, 1, 1, 0, 1'b1,
                          STATUS_REJECT));
    tbl.push_back(hdr_row(64'h2, 32'h9, 32'h9, 1, 0, 0, 1, 1, 32'h0, 1'b0, STATUS_STORED));
    tbl[$].dat[0] = 8'hFF;
    tbl[$].hd.sum = fnv_hash(tbl[$].dat, 1);
    tbl.push_back(hdr_row(64'h3, 32'hA, 32'hA, 1, 0, 0, 1, 1, 32'h0, 1'b1, STATUS_CKSUM));
    tbl[$].dat[0] = 8'h00;
    tbl[$].hd.sum = ~fnv_hash(tbl[$].dat, 1);
    tbl.push_back(hdr_row(64'h4, 32'hB, 32'hB, 4, 0, 0, 2, 0, 0, 1'b1, STATUS_STORED));
    tbl.push_back(hdr_row(64'h4, 32'hB, 32'hB, 5, 0, 1, 2, 1, 0, 1'b1, STATUS_MISMATCH));
    tbl.push_back(hdr_row(64'h4, 32'hB, 32'hB, 4, 0, 1, 2, 4, 0, 1'b0, STATUS_STORED));
    tbl[$].hd.sum = fnv_hash(tbl[$].dat, 4);
    foreach (tbl[i]) send_fragment(tbl[i]);

    tmo_set[0] = 16'd0;
    tmo_set[1] = 16'hFFFF;
    tmo_set[2] = 16'($urandom_range(1, 200));
    tmo_set[3] = 16'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      write_timeout(tmo_set[ph]);
      no_gaps = (ph == 2);
      random_burst();
    end
    no_gaps = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### fragment_reassembly_engine.f
hdl/fre_pkg.sv
hdl/fre_if.sv
hdl/fre_slot_mem.sv
hdl/fre_byte_mem.sv
hdl/fre_ctrl.sv
hdl/fragment_reassembly_engine.sv
hdl/fre_checker.sv
test/fragment_reassembly_engine_tb.sv
